[rtl/assert_macros.svh]
// Assertion macros used by the top level of the execute-step core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

[rtl/mse_pkg.sv]
// Package with the constants and types of the execute-step core.
`default_nettype none

package mse_pkg;

    localparam int DATA_WORDS_DEF = 1024;
    localparam int REG_COUNT      = 32;
    localparam int REG_AW         = 5;
    localparam int PIDX_W         = 10;
    localparam int CFG_IDX_W      = 2;

    localparam logic [31:0] TEXT_START_RST = 32'h0040_0000;
    localparam logic [31:0] TEXT_SIZE_RST  = 32'h0000_0000;
    localparam logic [31:0] DATA_START_RST = 32'h1000_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd2;

    // Operation codes of an input transaction.
    localparam logic OPERATION_EXECUTE = 1'b0;
    localparam logic OPERATION_PRELOAD = 1'b1;

    // Primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // Function codes under the special opcode.
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [REG_AW-1:0] LINK_REG = 5'd31;

    typedef logic [31:0] word_t;

    // One register file write.
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] idx;
        word_t             data;
    } rf_wr_t;

    // Operands of the execute unit.
    typedef struct packed {
        word_t       iw;
        word_t       a;
        word_t       b;
        word_t       pc;
        word_t       off;
        logic [32:0] bound;
    } exec_in_t;

    // Outcome of one executed instruction.
    typedef struct packed {
        word_t             next_pc;
        logic              halt;
        logic              wr_en;
        logic [REG_AW-1:0] wr_idx;
        word_t             wr_val;
        logic              ld;
        logic              st;
        word_t             st_addr;
        word_t             st_val;
        word_t             mem_sum;
    } exec_out_t;

endpackage

`default_nettype wire

[rtl/mse_channels.sv]
// Valid/ready channel interfaces for instruction transactions and step results.
`default_nettype none

interface mse_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [31:0]                 instruction_word;
    logic [mse_pkg::PIDX_W-1:0]  preload_index;
    logic [31:0]                 preload_value;

    modport source (
        output valid, operation, instruction_word, preload_index, preload_value,
        input  ready
    );
    modport sink (
        input  valid, operation, instruction_word, preload_index, preload_value,
        output ready
    );
endinterface

interface mse_res_if;
    logic                        valid;
    logic                        ready;
    logic [31:0]                 next_pc;
    logic                        running;
    logic                        reg_write_valid;
    logic [mse_pkg::REG_AW-1:0]  reg_write_index;
    logic [31:0]                 reg_write_value;
    logic                        store_valid;
    logic [31:0]                 store_address;
    logic [31:0]                 store_value;

    modport source (
        output valid, next_pc, running, reg_write_valid, reg_write_index,
               reg_write_value, store_valid, store_address, store_value,
        input  ready
    );
    modport sink (
        input  valid, next_pc, running, reg_write_valid, reg_write_index,
               reg_write_value, store_valid, store_address, store_value,
        output ready
    );
endinterface

`default_nettype wire

[rtl/mips_subset_execute_step_top.sv]
// Top level of the MIPS32 integer-subset execute-step core.
`default_nettype none
`include "assert_macros.svh"

// The core executes one instruction (or one data preload) per transaction and
// returns one result per transaction. It accepts a new transaction in every
// clock cycle unless the data memory is being cleared or the input register
// holds a transaction that cannot move on. A taken transaction first sits in
// the input register; its result is then offered from an output register.
// While a result waits there, one further transaction can be taken into the
// input register, after which input ready stays low until the result leaves.
// The rate is set by the single execute stage between the input register and
// the output register: the register file and data memory are synchronous-read
// RAMs, and results of the two most recent register writes, including a load
// that completes in the output stage, are forwarded into the execute stage.
// After reset the data memory is cleared one word per cycle with input ready
// held low; configuration writes are taken then. DATA_WORDS must be a power of two.
module mips_subset_execute_step_top #(
    parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]                     cfg_data,
    mse_cmd_if.sink                              cmd,
    mse_res_if.source                            res
);

    localparam int AW = $clog2(DATA_WORDS);
    localparam int PW = (AW > mse_pkg::PIDX_W) ? AW : mse_pkg::PIDX_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(DATA_WORDS - 1);

    // Configuration and architectural state.
    mse_pkg::word_t text_start_reg;
    mse_pkg::word_t text_size_reg;
    mse_pkg::word_t data_start_reg;
    mse_pkg::word_t pc_reg;
    logic           halted_reg;
    logic [32:0]    bound;

    // Data memory clearing after reset.
    logic           clr_busy_reg;
    logic [AW-1:0]  clr_addr_reg;

    // Input register.
    logic           s1_valid_reg;
    logic           s1_op_reg;
    mse_pkg::word_t s1_iw_reg;
    logic [AW-1:0]  s1_pidx_reg;
    mse_pkg::word_t s1_pval_reg;
    mse_pkg::word_t s1_off_reg;

    // Output register.
    logic                       s2_valid_reg;
    logic                       fresh_reg;
    mse_pkg::word_t             s2_next_pc_reg;
    logic                       s2_running_reg;
    logic                       s2_wr_valid_reg;
    logic [mse_pkg::REG_AW-1:0] s2_wr_idx_reg;
    mse_pkg::word_t             s2_wr_val_reg;
    logic                       s2_ld_reg;
    logic                       s2_st_valid_reg;
    mse_pkg::word_t             s2_st_addr_reg;
    mse_pkg::word_t             s2_st_val_reg;

    logic                       accept;
    logic                       transfer;
    logic                       commit;
    logic                       do_preload;
    logic [PW-1:0]              pidx_wide;
    mse_pkg::word_t             in_simm;
    logic [mse_pkg::REG_AW-1:0] ra_next;
    logic [mse_pkg::REG_AW-1:0] rb_next;
    mse_pkg::word_t             op_a;
    mse_pkg::word_t             op_b;
    mse_pkg::rf_wr_t            rf_wr;
    mse_pkg::exec_in_t          exe_in;
    mse_pkg::exec_out_t         exe;
    logic [AW-1:0]              mem_idx;
    logic                       dm_we;
    logic [AW-1:0]              dm_waddr;
    mse_pkg::word_t             dm_wdata;
    logic                       dm_re;
    mse_pkg::word_t             dm_q;

    assign bound      = {1'b0, text_start_reg} + {1'b0, text_size_reg};
    assign transfer   = s1_valid_reg && (!s2_valid_reg || res.ready);
    assign cmd.ready  = !clr_busy_reg && (!s1_valid_reg || transfer);
    assign accept     = cmd.valid && cmd.ready;
    assign commit     = transfer && (s1_op_reg == mse_pkg::OPERATION_EXECUTE) && !halted_reg;
    assign do_preload = transfer && (s1_op_reg == mse_pkg::OPERATION_PRELOAD);
    assign pidx_wide  = PW'(cmd.preload_index);
    assign in_simm    = {{16{cmd.instruction_word[15]}}, cmd.instruction_word[15:0]};

    // Operand reads are issued for whichever instruction sits in the input
    // register during the next cycle.
    assign ra_next = accept ? cmd.instruction_word[25:21] : s1_iw_reg[25:21];
    assign rb_next = accept ? cmd.instruction_word[20:16] : s1_iw_reg[20:16];

    // The output stage writes back during its first cycle; a load takes its
    // value straight from the data memory read port.
    assign rf_wr.en   = fresh_reg && s2_wr_valid_reg;
    assign rf_wr.idx  = s2_wr_idx_reg;
    assign rf_wr.data = s2_ld_reg ? dm_q : s2_wr_val_reg;

    mse_rf u_rf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ra_next (ra_next),
        .rb_next (rb_next),
        .wr      (rf_wr),
        .a       (op_a),
        .b       (op_b)
    );

    assign exe_in.iw    = s1_iw_reg;
    assign exe_in.a     = op_a;
    assign exe_in.b     = op_b;
    assign exe_in.pc    = pc_reg;
    assign exe_in.off   = s1_off_reg;
    assign exe_in.bound = bound;

    mse_exec u_exec (
        .ex_in  (exe_in),
        .ex_out (exe)
    );

    // The word index is the byte offset from the data base, divided by four.
    assign mem_idx  = exe.mem_sum[AW+1:2];
    assign dm_we    = clr_busy_reg || do_preload || (commit && exe.st);
    assign dm_waddr = clr_busy_reg ? clr_addr_reg : (do_preload ? s1_pidx_reg : mem_idx);
    assign dm_wdata = clr_busy_reg ? '0 : (do_preload ? s1_pval_reg : exe.st_val);
    assign dm_re    = commit && exe.ld;

    mse_ram #(
        .WIDTH (32),
        .DEPTH (DATA_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (dm_re),
        .raddr (mem_idx),
        .rdata (dm_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_size_reg  <= mse_pkg::TEXT_SIZE_RST;
            data_start_reg <= mse_pkg::DATA_START_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mse_pkg::CFG_TEXT_SIZE:  text_size_reg  <= cfg_data;
                mse_pkg::CFG_DATA_START: data_start_reg <= cfg_data;
                default:                 text_size_reg  <= text_size_reg;
            endcase
        end
    end

    // Writing the text start also moves the program counter there.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_start_reg <= mse_pkg::TEXT_START_RST;
            pc_reg         <= mse_pkg::TEXT_START_RST;
            halted_reg     <= 1'b0;
        end
        else if (cfg_we && (cfg_index == mse_pkg::CFG_TEXT_START))
        begin
            text_start_reg <= cfg_data;
            pc_reg         <= cfg_data;
        end
        else if (commit)
        begin
            pc_reg <= exe.next_pc;
            if (exe.halt)
            begin
                halted_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST_WORD)
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (transfer)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= cmd.operation;
            s1_iw_reg   <= cmd.instruction_word;
            s1_pidx_reg <= pidx_wide[AW-1:0];
            s1_pval_reg <= cmd.preload_value;
            s1_off_reg  <= in_simm - data_start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            fresh_reg    <= 1'b0;
        end
        else
        begin
            fresh_reg <= transfer;
            if (transfer)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (transfer)
        begin
            if (commit)
            begin
                s2_next_pc_reg  <= exe.next_pc;
                s2_running_reg  <= !exe.halt;
                s2_wr_valid_reg <= exe.wr_en;
                s2_wr_idx_reg   <= exe.wr_idx;
                s2_wr_val_reg   <= exe.wr_val;
                s2_ld_reg       <= exe.ld;
                s2_st_valid_reg <= exe.st;
                s2_st_addr_reg  <= exe.st_addr;
                s2_st_val_reg   <= exe.st_val;
            end
            else
            begin
                s2_next_pc_reg  <= pc_reg;
                s2_running_reg  <= !halted_reg;
                s2_wr_valid_reg <= 1'b0;
                s2_wr_idx_reg   <= '0;
                s2_wr_val_reg   <= '0;
                s2_ld_reg       <= 1'b0;
                s2_st_valid_reg <= 1'b0;
                s2_st_addr_reg  <= '0;
                s2_st_val_reg   <= '0;
            end
        end
        else if (fresh_reg && s2_ld_reg)
        begin
            // Keep the loaded word once the memory read port moves on.
            s2_wr_val_reg <= dm_q;
        end
    end

    assign res.valid           = s2_valid_reg;
    assign res.next_pc         = s2_next_pc_reg;
    assign res.running         = s2_running_reg;
    assign res.reg_write_valid = s2_wr_valid_reg;
    assign res.reg_write_index = s2_wr_idx_reg;
    assign res.reg_write_value = (fresh_reg && s2_ld_reg) ? dm_q : s2_wr_val_reg;
    assign res.store_valid     = s2_st_valid_reg;
    assign res.store_address   = s2_st_addr_reg;
    assign res.store_value     = s2_st_val_reg;

    `ASSERT_IMPLY(a_no_accept_while_clearing, clk, rst_n, clr_busy_reg, !cmd.ready)
    `ASSERT_IMPLY(a_no_write_to_zero, clk, rst_n, rf_wr.en, rf_wr.idx != '0)
    `ASSERT_NEXT(a_halt_is_sticky, clk, rst_n, halted_reg, halted_reg)
    `ASSERT_NEXT(a_move_fills_output, clk, rst_n, transfer, fresh_reg && s2_valid_reg)

endmodule

`default_nettype wire

[rtl/mse_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/mse_rf.sv]
// General register file: two RAM copies, per-entry valid bits and write forwarding.
`default_nettype none

module mse_rf (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [mse_pkg::REG_AW-1:0]   ra_next,
    input  wire logic [mse_pkg::REG_AW-1:0]   rb_next,
    input  wire mse_pkg::rf_wr_t              wr,
    output      mse_pkg::word_t               a,
    output      mse_pkg::word_t               b
);

    logic [mse_pkg::REG_COUNT-1:0] valid_reg;
    logic [mse_pkg::REG_AW-1:0]    ra_reg;
    logic [mse_pkg::REG_AW-1:0]    rb_reg;
    logic                          a_ok_reg;
    logic                          b_ok_reg;
    mse_pkg::rf_wr_t               last_wr_reg;
    mse_pkg::word_t                qa;
    mse_pkg::word_t                qb;

    mse_ram #(
        .WIDTH (32),
        .DEPTH (mse_pkg::REG_COUNT)
    ) u_bank_a (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.data),
        .re    (1'b1),
        .raddr (ra_next),
        .rdata (qa)
    );

    mse_ram #(
        .WIDTH (32),
        .DEPTH (mse_pkg::REG_COUNT)
    ) u_bank_b (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.data),
        .re    (1'b1),
        .raddr (rb_next),
        .rdata (qb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            ra_reg      <= '0;
            rb_reg      <= '0;
            a_ok_reg    <= 1'b0;
            b_ok_reg    <= 1'b0;
            last_wr_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            ra_reg      <= ra_next;
            rb_reg      <= rb_next;
            a_ok_reg    <= valid_reg[ra_next];
            b_ok_reg    <= valid_reg[rb_next];
            last_wr_reg <= wr;
        end
    end

    // The RAM data misses the write in progress and the one made at the read edge.
    always_comb
    begin
        if (wr.en && (wr.idx == ra_reg))
        begin
            a = wr.data;
        end
        else if (last_wr_reg.en && (last_wr_reg.idx == ra_reg))
        begin
            a = last_wr_reg.data;
        end
        else if (a_ok_reg)
        begin
            a = qa;
        end
        else
        begin
            a = '0;
        end

        if (wr.en && (wr.idx == rb_reg))
        begin
            b = wr.data;
        end
        else if (last_wr_reg.en && (last_wr_reg.idx == rb_reg))
        begin
            b = last_wr_reg.data;
        end
        else if (b_ok_reg)
        begin
            b = qb;
        end
        else
        begin
            b = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/mse_exec.sv]
// Instruction decode, ALU, branch and jump resolution for one instruction.
`default_nettype none

module mse_exec (
    input  wire mse_pkg::exec_in_t  ex_in,
    output      mse_pkg::exec_out_t ex_out
);

    logic [5:0]                 opc;
    logic [5:0]                 fn;
    logic [mse_pkg::REG_AW-1:0] rt_n;
    logic [mse_pkg::REG_AW-1:0] rd_n;
    logic [4:0]                 sh;
    mse_pkg::word_t             zimm;
    mse_pkg::word_t             simm;
    mse_pkg::word_t             pc4;
    mse_pkg::word_t             br_tgt;
    mse_pkg::word_t             j_tgt;
    logic                       lt_s;
    logic                       lt_u;
    logic                       lt_imm;

    mse_pkg::word_t             npc;
    logic                       wr;
    logic [mse_pkg::REG_AW-1:0] widx;
    mse_pkg::word_t             wval;
    logic                       ld;
    logic                       st;

    assign opc    = ex_in.iw[31:26];
    assign rt_n   = ex_in.iw[20:16];
    assign rd_n   = ex_in.iw[15:11];
    assign sh     = ex_in.iw[10:6];
    assign fn     = ex_in.iw[5:0];
    assign zimm   = {16'h0000, ex_in.iw[15:0]};
    assign simm   = {{16{ex_in.iw[15]}}, ex_in.iw[15:0]};
    assign pc4    = ex_in.pc + 32'd4;
    assign br_tgt = pc4 + {simm[29:0], 2'b00};
    assign j_tgt  = {pc4[31:28], ex_in.iw[25:0], 2'b00};
    assign lt_s   = $signed(ex_in.a) < $signed(ex_in.b);
    assign lt_u   = ex_in.a < ex_in.b;
    assign lt_imm = ex_in.a < simm;

    always_comb
    begin
        npc  = pc4;
        wr   = 1'b0;
        widx = rt_n;
        wval = '0;
        ld   = 1'b0;
        st   = 1'b0;

        unique case (opc)
            mse_pkg::OP_SPECIAL:
            begin
                wr   = 1'b1;
                widx = rd_n;
                unique case (fn) inside
                    mse_pkg::FN_ADDU:                  wval = ex_in.a + ex_in.b;
                    mse_pkg::FN_AND:                   wval = ex_in.a & ex_in.b;
                    mse_pkg::FN_NOR:                   wval = ~(ex_in.a | ex_in.b);
                    mse_pkg::FN_OR:                    wval = ex_in.a | ex_in.b;
                    mse_pkg::FN_SLT:                   wval = {31'd0, lt_s};
                    mse_pkg::FN_SLTU:                  wval = {31'd0, lt_u};
                    mse_pkg::FN_SLL:                   wval = ex_in.b << sh;
                    mse_pkg::FN_SRL:                   wval = ex_in.b >> sh;
                    mse_pkg::FN_SUB, mse_pkg::FN_SUBU: wval = ex_in.a - ex_in.b;
                    mse_pkg::FN_JR:
                    begin
                        wr  = 1'b0;
                        npc = ex_in.a;
                    end
                    default:                           wr = 1'b0;
                endcase
            end
            mse_pkg::OP_ADDIU:
            begin
                wr   = 1'b1;
                wval = ex_in.a + simm;
            end
            mse_pkg::OP_ANDI:
            begin
                wr   = 1'b1;
                wval = ex_in.a & zimm;
            end
            mse_pkg::OP_LUI:
            begin
                wr   = 1'b1;
                wval = {ex_in.iw[15:0], 16'h0000};
            end
            mse_pkg::OP_ORI:
            begin
                wr   = 1'b1;
                wval = ex_in.a | zimm;
            end
            mse_pkg::OP_SLTIU:
            begin
                wr   = 1'b1;
                wval = {31'd0, lt_imm};
            end
            mse_pkg::OP_LW:
            begin
                wr = 1'b1;
                ld = 1'b1;
            end
            mse_pkg::OP_SW:
            begin
                st = 1'b1;
            end
            mse_pkg::OP_BEQ:
            begin
                if (ex_in.a == ex_in.b)
                begin
                    npc = br_tgt;
                end
            end
            mse_pkg::OP_BNE:
            begin
                if (ex_in.a != ex_in.b)
                begin
                    npc = br_tgt;
                end
            end
            mse_pkg::OP_JAL:
            begin
                wr   = 1'b1;
                widx = mse_pkg::LINK_REG;
                wval = ex_in.pc + 32'd8;
                npc  = j_tgt;
            end
            mse_pkg::OP_J:
            begin
                npc = j_tgt;
            end
            default:
            begin
                npc = pc4;
            end
        endcase

        // Register zero is never written, and such a write is not reported.
        if (widx == '0)
        begin
            wr = 1'b0;
        end

        ex_out.next_pc = npc;
        ex_out.halt    = {1'b0, npc} >= ex_in.bound;
        ex_out.wr_en   = wr;
        ex_out.wr_idx  = wr ? widx : '0;
        ex_out.wr_val  = wr ? wval : '0;
        ex_out.ld      = ld && wr;
        ex_out.st      = st;
        ex_out.st_addr = st ? (ex_in.a + simm) : '0;
        ex_out.st_val  = st ? ex_in.b : '0;
        ex_out.mem_sum = ex_in.a + ex_in.off;
    end

endmodule

`default_nettype wire
